FILE: hdl/ektl_pkg.sv
// shared types and constants of the expiring key table
`default_nettype none
package ektl_pkg;
  localparam int KEY_WORDS = 4;
  localparam int LEN_W = 6;
  localparam int EXP_W = 32;

  // commands from controller to datapath
  typedef struct packed {
    logic load;        // capture request fields
    logic cmp_start;   // reset compaction pointers
    logic cmp_step;    // process one source entry
    logic cmp_done;    // latch compacted count
    logic srch_start;  // reset search pointer
    logic srch_step;   // compare one entry
    logic add;         // append entry
    logic finish;      // load result register
  } ektl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic cmp_last;    // last source entry issued
    logic srch_last;   // search finished (hit or end)
    logic is_add;      // request is an add
  } ektl_sts_t;
endpackage
`default_nettype wire

FILE: hdl/ektl_if.sv
// valid/ready channel interfaces for requests and results
`default_nettype none
interface ektl_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [5:0]  key_length;
  logic [63:0] key_word_0;
  logic [63:0] key_word_1;
  logic [63:0] key_word_2;
  logic [63:0] key_word_3;
  logic [31:0] expires_at;
  logic [31:0] current_time;
  modport source (output valid, operation, key_length, key_word_0, key_word_1,
                  key_word_2, key_word_3, expires_at, current_time, input ready);
  modport sink (input valid, operation, key_length, key_word_0, key_word_1,
                key_word_2, key_word_3, expires_at, current_time, output ready);
endinterface

interface ektl_rsp_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [5:0] entry_index;
  logic       table_full;
  logic [6:0] entry_count;
  modport source (output valid, hit, entry_index, table_full, entry_count,
                  input ready);
  modport sink (input valid, hit, entry_index, table_full, entry_count,
                output ready);
endinterface
`default_nettype wire

FILE: hdl/expiring_key_table_lookup.sv
// top level of the expiring key table with expiry compaction and linear search
// a request passes through compaction of expired entries, one turnaround step that latches
// the compacted count, a linear search (find) or a single append (add), and a finish step
// one transaction at a time: a new request is accepted only once the previous one is finished
// the finish step stalls only while the previous result is still unread
// reset: synchronous, empties the table (live count 0); entry memory is not cleared
`default_nettype none
module expiring_key_table_lookup #(
  parameter int CAPACITY = 64,
  parameter int MAX_KEY_BYTES = 32
) (
  input wire logic clk,
  input wire logic rst,
  ektl_req_if.sink   req,
  ektl_rsp_if.source rsp
);
  ektl_pkg::ektl_cmd_t cmd;
  ektl_pkg::ektl_sts_t sts;

  // controller
  ektl_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .sts(sts), .cmd(cmd)
  );

  // datapath
  ektl_dp #(.CAPACITY(CAPACITY), .MAX_KEY_BYTES(MAX_KEY_BYTES)) u_dp (
    .clk(clk), .rst(rst),
    .operation(req.operation), .key_length(req.key_length),
    .key_word_0(req.key_word_0), .key_word_1(req.key_word_1),
    .key_word_2(req.key_word_2), .key_word_3(req.key_word_3),
    .expires_at(req.expires_at), .current_time(req.current_time),
    .cmd(cmd), .sts(sts),
    .hit(rsp.hit), .entry_index(rsp.entry_index),
    .table_full(rsp.table_full), .entry_count(rsp.entry_count)
  );
endmodule
`default_nettype wire

FILE: hdl/ektl_ctrl.sv
// controller state machine of the expiring key table
`default_nettype none
module ektl_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire ektl_pkg::ektl_sts_t sts,
  output ektl_pkg::ektl_cmd_t cmd
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CMP  = 6'b000010,
    S_DRN  = 6'b000100,
    S_SRCH = 6'b001000,
    S_ADD  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   busy;

  // sequencing
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          cmd.cmp_start = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp_step = 1'b1;
        if (sts.cmp_last) state_next = S_DRN;
      end
      S_DRN: begin
        cmd.cmp_done = 1'b1;
        cmd.srch_start = 1'b1;
        state_next = sts.is_add ? S_ADD : S_SRCH;
      end
      S_SRCH: begin
        cmd.srch_step = 1'b1;
        if (sts.srch_last) state_next = S_FIN;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        // wait until the output register is free
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // result register: holds one transaction until taken
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.finish) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  assign busy = (state != S_IDLE);
  assign in_ready = !busy;

  a_fin_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid) else $error("finish did not raise valid");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready) else $error("ready while busy");
  a_one_hot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");
endmodule
`default_nettype wire

FILE: hdl/ektl_dp.sv
// datapath: entry memories, compaction and search pointers, result fields
`default_nettype none
module ektl_dp #(
  parameter int CAPACITY = 64,
  parameter int MAX_KEY_BYTES = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic        operation,
  input  wire logic [5:0]  key_length,
  input  wire logic [63:0] key_word_0,
  input  wire logic [63:0] key_word_1,
  input  wire logic [63:0] key_word_2,
  input  wire logic [63:0] key_word_3,
  input  wire logic [31:0] expires_at,
  input  wire logic [31:0] current_time,
  input  wire ektl_pkg::ektl_cmd_t cmd,
  output ektl_pkg::ektl_sts_t sts,
  output logic       hit,
  output logic [5:0] entry_index,
  output logic       table_full,
  output logic [6:0] entry_count
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = AW + 1;
  localparam int EW = ektl_pkg::LEN_W + ektl_pkg::EXP_W + 64 * ektl_pkg::KEY_WORDS;

  // one wide entry: key, length, expiry
  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_data;
  logic [AW-1:0] rd_addr;

  logic          req_op;
  logic [5:0]    req_len;
  logic [255:0]  req_key;
  logic [31:0]   req_exp;
  logic [31:0]   req_now;

  logic [CW-1:0] live;       // live entries
  logic [CW-1:0] src;        // compaction read pointer
  logic [CW-1:0] dst;        // compaction write pointer
  logic          rd_vld;     // read data valid for compaction
  logic [CW-1:0] sptr;       // search read pointer
  logic [CW-1:0] sidx;       // index of entry in rd_data during search
  logic          s_vld;
  logic          found;
  logic [CW-1:0] found_idx;
  logic          full_flag;

  logic [255:0]  key_mask;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          entry_match;
  logic [5:0]    len_cap;

  logic          res_hit;    // result of the operation, before the output register
  logic [5:0]    res_idx;
  logic          res_full;

  // byte mask of valid key bytes
  always_comb begin
    len_cap = (key_length > 6'(MAX_KEY_BYTES)) ? 6'(MAX_KEY_BYTES) : key_length;
    for (int b = 0; b < 32; b++) key_mask[b*8 +: 8] = (6'(b) < len_cap) ? 8'hff : 8'h00;
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op  <= operation;
      req_len <= key_length;
      req_key <= {key_word_3, key_word_2, key_word_1, key_word_0} & key_mask;
      req_exp <= expires_at;
      req_now <= current_time;
    end
  end

  // read address: compaction source or search pointer
  assign rd_addr = cmd.srch_step ? sptr[AW-1:0] : src[AW-1:0];

  // memory write: compaction move or append
  always_comb begin
    wr_en = 1'b0;
    wr_addr = dst[AW-1:0];
    wr_data = rd_data;
    if (cmd.add && !full_flag) begin
      wr_en = 1'b1;
      wr_addr = live[AW-1:0];
      wr_data = {req_len, req_exp, req_key};
    end else if (rd_vld && (rd_data[255+32 -: 32] >= req_now)) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  assign entry_match = (rd_data[EW-1 -: 6] == req_len) && (rd_data[255:0] == req_key);
  assign full_flag = (live == CW'(CAPACITY));

  // compaction and search pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
      src <= '0;
      dst <= '0;
      rd_vld <= 1'b0;
      sptr <= '0;
      s_vld <= 1'b0;
      found <= 1'b0;
    end else begin
      if (cmd.cmp_start) begin
        src <= '0;
        dst <= '0;
        rd_vld <= 1'b0;
      end
      if (cmd.cmp_step || cmd.cmp_done) begin
        rd_vld <= cmd.cmp_step && (src < live);
        if (cmd.cmp_step && src < live) src <= src + 1'b1;
        if (wr_en) dst <= dst + 1'b1;
      end
      if (cmd.cmp_done) begin
        live <= wr_en ? dst + 1'b1 : dst;
      end
      if (cmd.srch_start) begin
        sptr <= '0;
        s_vld <= 1'b0;
        found <= 1'b0;
      end
      if (cmd.srch_step) begin
        s_vld <= sptr < live;
        sidx <= sptr;
        if (sptr < live) sptr <= sptr + 1'b1;
        if (s_vld && entry_match && !found) begin
          found <= 1'b1;
          found_idx <= sidx;
        end
      end
      if (cmd.add && !full_flag) live <= live + 1'b1;
    end
  end

  assign sts.cmp_last = !(src < live);
  assign sts.srch_last = (s_vld && entry_match) || (!s_vld && sptr != '0 && !(sptr < live))
                         || (!s_vld && live == '0) || (s_vld && !(sptr < live) && !entry_match);
  assign sts.is_add = req_op;

  // result of the operation
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      res_hit <= !full_flag;
      res_idx <= full_flag ? 6'd0 : 6'(live);
      res_full <= full_flag;
    end
    if (cmd.srch_step && sts.srch_last) begin
      res_hit <= found || (s_vld && entry_match);
      res_idx <= found ? 6'(found_idx) : ((s_vld && entry_match) ? 6'(sidx) : 6'd0);
      res_full <= 1'b0;
    end
  end

  // output register, loaded once the previous transaction is taken
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      hit <= res_hit;
      entry_index <= res_idx;
      table_full <= res_full;
      entry_count <= 7'(live);
    end
  end

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live <= CW'(CAPACITY)) else $error("live count over capacity");
  a_dst_src: assert property (@(posedge clk) disable iff (rst)
    dst <= src) else $error("compaction write passed read");
  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.add && !full_flag |=> live == $past(live) + 1'b1) else $error("add lost");
endmodule
`default_nettype wire
